// File: hw/rtl/sct_pkg.sv
`default_nettype none

package sct_pkg;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_SINGLE = 2'd1,
    MODE_DOUBLE = 2'd2
  } lex_mode_e;

  localparam logic [3:0] KIND_WORD   = 4'd0;
  localparam logic [3:0] KIND_PIPE   = 4'd1;
  localparam logic [3:0] KIND_BG     = 4'd2;
  localparam logic [3:0] KIND_IN     = 4'd3;
  localparam logic [3:0] KIND_OUT    = 4'd4;
  localparam logic [3:0] KIND_STDERR = 4'd5;
  localparam logic [3:0] KIND_APPEND = 4'd6;
  localparam logic [3:0] KIND_AND    = 4'd7;
  localparam logic [3:0] KIND_OR     = 4'd8;

  localparam logic [1:0] QUOTE_NONE   = 2'd0;
  localparam logic [1:0] QUOTE_SINGLE = 2'd1;
  localparam logic [1:0] QUOTE_DOUBLE = 2'd2;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_UNTERM   = 2'd1;
  localparam logic [1:0] STATUS_ESCAPE   = 2'd2;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_DQ    = 8'h22;
  localparam logic [7:0] CHAR_SQ    = 8'h27;
  localparam logic [7:0] CHAR_AMP   = 8'h26;
  localparam logic [7:0] CHAR_TWO   = 8'h32;
  localparam logic [7:0] CHAR_LT    = 8'h3C;
  localparam logic [7:0] CHAR_GT    = 8'h3E;
  localparam logic [7:0] CHAR_BSL   = 8'h5C;
  localparam logic [7:0] CHAR_PIPE  = 8'h7C;

  typedef struct packed {
    logic [7:0] ch;
    logic [7:0] next_ch;
  } in_req_t;

  typedef struct packed {
    logic       part_end_before;
    logic       tok_end_before;
    logic       tok_begin;
    logic [3:0] tok_kind;
    logic       part_begin;
    logic [1:0] part_quote;
    logic       empty_part;
    logic       byte_valid;
    logic [7:0] byte_value;
    logic       command_end;
    logic [1:0] status;
  } out_req_t;

  typedef struct packed {
    lex_mode_e  mode;
    logic       token_open;
    logic       part_open;
    logic [1:0] skip_count;
    logic       skip_appends;
    logic       discarding;
  } lex_state_t;

  localparam lex_state_t LEX_STATE_RESET = '0;

endpackage

`default_nettype wire

// File: hw/rtl/sct_step.sv
`default_nettype none

module sct_step (
  input  wire sct_pkg::lex_state_t state_i,
  input  wire sct_pkg::in_req_t    req_i,
  output sct_pkg::lex_state_t      state_o,
  output sct_pkg::out_req_t        res_o
);

  logic       last;
  logic       is_dbl;
  logic [7:0] close_q_char;
  logic [3:0] op_kind;
  logic       op_two;
  logic [1:0] err;

  assign last         = (req_i.next_ch == sct_pkg::CHAR_NUL);
  assign is_dbl       = (req_i.ch == sct_pkg::CHAR_DQ);
  assign close_q_char = (state_i.mode == sct_pkg::MODE_DOUBLE) ? sct_pkg::CHAR_DQ
                                                                : sct_pkg::CHAR_SQ;

  always_comb begin
    op_two  = 1'b1;
    op_kind = sct_pkg::KIND_WORD;
    priority if (req_i.ch == sct_pkg::CHAR_TWO && req_i.next_ch == sct_pkg::CHAR_GT) begin
      op_kind = sct_pkg::KIND_STDERR;
    end else if (req_i.ch == sct_pkg::CHAR_GT && req_i.next_ch == sct_pkg::CHAR_GT) begin
      op_kind = sct_pkg::KIND_APPEND;
    end else if (req_i.ch == sct_pkg::CHAR_AMP && req_i.next_ch == sct_pkg::CHAR_AMP) begin
      op_kind = sct_pkg::KIND_AND;
    end else if (req_i.ch == sct_pkg::CHAR_PIPE && req_i.next_ch == sct_pkg::CHAR_PIPE) begin
      op_kind = sct_pkg::KIND_OR;
    end else begin
      op_two = 1'b0;
      priority if (req_i.ch == sct_pkg::CHAR_PIPE) begin
        op_kind = sct_pkg::KIND_PIPE;
      end else if (req_i.ch == sct_pkg::CHAR_AMP) begin
        op_kind = sct_pkg::KIND_BG;
      end else if (req_i.ch == sct_pkg::CHAR_LT) begin
        op_kind = sct_pkg::KIND_IN;
      end else if (req_i.ch == sct_pkg::CHAR_GT) begin
        op_kind = sct_pkg::KIND_OUT;
      end else begin
        op_kind = sct_pkg::KIND_WORD;
      end
    end
  end

  always_comb begin
    res_o   = '0;
    state_o = state_i;
    err     = sct_pkg::STATUS_OK;
    if (state_i.discarding) begin
      if (last) begin
        state_o = sct_pkg::LEX_STATE_RESET;
      end
    end else begin
      priority if (state_i.skip_count != 2'd0) begin
        state_o.skip_count = state_i.skip_count - 2'd1;
        if (state_i.skip_appends) begin
          res_o.byte_valid = 1'b1;
          res_o.byte_value = req_i.ch;
        end
        if (state_i.skip_count == 2'd1) begin
          state_o.skip_appends = 1'b0;
        end
        if (last && state_i.mode != sct_pkg::MODE_NORMAL) begin
          err = (state_i.skip_count == 2'd2) ? sct_pkg::STATUS_ESCAPE
                                             : sct_pkg::STATUS_UNTERM;
        end
      end else if (state_i.mode != sct_pkg::MODE_NORMAL) begin
        if (req_i.ch == close_q_char) begin
          res_o.part_end_before = 1'b1;
          state_o.part_open     = 1'b0;
          state_o.mode          = sct_pkg::MODE_NORMAL;
        end else begin
          res_o.byte_valid = 1'b1;
          res_o.byte_value = req_i.ch;
          if (last) begin
            err = sct_pkg::STATUS_UNTERM;
          end
        end
      end else if (req_i.ch == sct_pkg::CHAR_DQ || req_i.ch == sct_pkg::CHAR_SQ) begin
        if (last) begin
          err = sct_pkg::STATUS_UNTERM;
        end else begin
          res_o.part_end_before = state_i.part_open;
          state_o.part_open     = 1'b0;
          if (!state_i.token_open) begin
            res_o.tok_begin    = 1'b1;
            state_o.token_open = 1'b1;
          end
          res_o.part_begin = 1'b1;
          res_o.part_quote = is_dbl ? sct_pkg::QUOTE_DOUBLE : sct_pkg::QUOTE_SINGLE;
          if (req_i.next_ch == req_i.ch) begin
            res_o.empty_part     = 1'b1;
            state_o.skip_count   = 2'd1;
            state_o.skip_appends = 1'b0;
          end else begin
            state_o.part_open    = 1'b1;
            state_o.mode         = is_dbl ? sct_pkg::MODE_DOUBLE : sct_pkg::MODE_SINGLE;
            state_o.skip_count   = (is_dbl && req_i.next_ch == sct_pkg::CHAR_BSL) ? 2'd2
                                                                                 : 2'd1;
            state_o.skip_appends = 1'b1;
          end
        end
      end else if (req_i.ch == sct_pkg::CHAR_SPACE) begin
        res_o.part_end_before = state_i.part_open;
        res_o.tok_end_before  = state_i.token_open;
        state_o.part_open     = 1'b0;
        state_o.token_open    = 1'b0;
      end else if (op_kind != sct_pkg::KIND_WORD) begin
        res_o.part_end_before = state_i.part_open;
        res_o.tok_end_before  = state_i.token_open;
        state_o.part_open     = 1'b0;
        state_o.token_open    = 1'b0;
        res_o.tok_begin       = 1'b1;
        res_o.tok_kind        = op_kind;
        if (op_two) begin
          state_o.skip_count   = 2'd1;
          state_o.skip_appends = 1'b0;
        end
      end else begin
        if (!state_i.token_open) begin
          res_o.tok_begin    = 1'b1;
          state_o.token_open = 1'b1;
        end
        if (!state_i.part_open) begin
          res_o.part_begin  = 1'b1;
          state_o.part_open = 1'b1;
        end
        res_o.byte_valid = 1'b1;
        res_o.byte_value = req_i.ch;
        if (req_i.ch == sct_pkg::CHAR_BSL) begin
          if (last) begin
            err = sct_pkg::STATUS_ESCAPE;
          end else begin
            state_o.skip_count   = 2'd1;
            state_o.skip_appends = 1'b1;
          end
        end
      end

      if (err != sct_pkg::STATUS_OK) begin
        res_o              = '0;
        res_o.status       = err;
        state_o            = sct_pkg::LEX_STATE_RESET;
        state_o.discarding = !last;
      end else if (last) begin
        res_o.command_end = 1'b1;
        state_o           = sct_pkg::LEX_STATE_RESET;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/shell_command_tokenizer_unit.sv
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid_i / in_stall_o  | in_req_i  (sct_pkg::in_req_t)
// out     | output    | out_valid_o / out_stall_i | out_req_o (sct_pkg::out_req_t)
//
// One request per cycle sustained while the output does not stall; a request passes the input
// register, then one decode stage, then the result register, before its result is valid.
// Reset clears the lexer state and both valid flags; no clearing pass is needed.
// A stalled result holds; the input register still takes a request while the result waits, if it is empty.
// in_stall_o rises only when both registers are full and the output is stalled.
`default_nettype none

module shell_command_tokenizer_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire sct_pkg::in_req_t   in_req_i,
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output sct_pkg::out_req_t       out_req_o
);

  logic                s1_valid_q;
  logic                s1_valid_d;
  sct_pkg::in_req_t    s1_req_q;
  sct_pkg::lex_state_t state_q;
  sct_pkg::lex_state_t state_d;
  sct_pkg::out_req_t   step_res;
  logic                out_valid_q;
  logic                out_valid_d;
  sct_pkg::out_req_t   out_req_q;
  logic                out_ready;
  logic                s1_advance;
  logic                in_accept;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s1_advance = s1_valid_q && out_ready;
  assign in_stall_o = s1_valid_q && !out_ready;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign s1_valid_d  = in_accept ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_q);
  assign out_valid_d = s1_advance ? 1'b1 : (out_valid_q && out_stall_i);

  sct_step u_step (
    .state_i (state_q),
    .req_i   (s1_req_q),
    .state_o (state_d),
    .res_o   (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= sct_pkg::LEX_STATE_RESET;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_advance) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_req_q <= in_req_i;
    end
    if (s1_advance) begin
      out_req_q <= step_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_req_o.status != sct_pkg::STATUS_OK
      |-> !out_req_o.command_end && !out_req_o.byte_valid && !out_req_o.tok_begin)
    else $error("error result carries extra fields");

  a_discard_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.discarding |-> state_q.skip_count == 2'd0 && state_q.mode == sct_pkg::MODE_NORMAL
                           && !state_q.token_open && !state_q.part_open)
    else $error("discarding with live lexer state");

  a_last_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_advance && s1_req_q.next_ch == sct_pkg::CHAR_NUL |=> state_q == sct_pkg::LEX_STATE_RESET)
    else $error("state not cleared after last byte");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q)
    else $error("input stalled with free register");

  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_req_o.byte_valid |-> out_req_o.byte_value == 8'h00)
    else $error("byte value without byte valid");

endmodule

`default_nettype wire
